/* rtl/core/shfr_pkg.sv */
// Shared types and constants of the sync header frame receiver.
package shfr_pkg;

    // Frame buffer geometry
    localparam int BUFFER_BYTES = 128;
    localparam int AW           = $clog2(BUFFER_BYTES);
    localparam int IW           = 8;

    // Byte codes
    localparam logic [7:0] SYNC_FIRST   = 8'hA5;
    localparam logic [7:0] SYNC_SECOND  = 8'h5A;
    localparam logic [7:0] CMD_POSITION = 8'hA6;
    localparam logic [7:0] CMD_INIT     = 8'hA9;

    // Command kinds reported with a result
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_POS  = 2'd1;
    localparam logic [1:0] KIND_INIT = 2'd2;

    localparam logic [15:0] STEER_RESET = 16'd1400;

    // Output tdata width: 37 field bits padded to whole bytes
    localparam int RES_BITS  = 37;
    localparam int RES_BYTES = (RES_BITS + 7) / 8;

    typedef logic [7:0]    t_byte;
    typedef logic [AW-1:0] t_addr;

    // Frame store access from the controller
    typedef struct packed {
        logic  wr_en;
        t_addr wr_addr;
        t_byte wr_data;
        logic  rd_en;
        t_addr rd_addr;
    } t_mem_req;

    // One result item
    typedef struct packed {
        logic        frame_done;
        logic        checksum_ok;
        logic [1:0]  command_kind;
        logic [15:0] steer_position;
        logic [15:0] sail_position;
        logic        init_seen;
    } t_result;

endpackage

/* rtl/core/shfr_store.sv */
// Frame byte store: one write and one registered read port, per-entry valid bits.
module shfr_store (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  shfr_pkg::t_mem_req i_req,
    output shfr_pkg::t_byte  o_rd_data
);
    import shfr_pkg::*;

    t_byte                   mem [BUFFER_BYTES];
    logic [BUFFER_BYTES-1:0] r_vld;
    t_byte                   r_rd_data;
    logic                    r_rd_vld;

    // Write the array
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // Mark written entries; reset makes every entry read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_req.wr_en) begin
            r_vld[i_req.wr_addr] <= 1'b1;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= mem[i_req.rd_addr];
            r_rd_vld  <= r_vld[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

/* rtl/core/shfr_ctrl.sv */
// Receive sequencer: index and header tracking, checksum walk, latched positions.
module shfr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_byte_vld,
    input  shfr_pkg::t_byte    i_byte,
    output logic               o_byte_rdy,
    output shfr_pkg::t_mem_req o_mem_req,
    input  shfr_pkg::t_byte    i_rd_data,
    output logic               o_res_vld,
    output shfr_pkg::t_result  o_res,
    input  logic               i_res_rdy
);
    import shfr_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;
    logic          r_hdr, n_hdr;
    t_byte         r_len, n_len;
    logic [15:0]   r_steer, n_steer;
    logic [15:0]   r_sail, n_sail;
    logic          r_init, n_init;
    logic          r_len_ok, n_len_ok;
    t_byte         r_lim, n_lim;
    t_addr         r_end, n_end;
    t_addr         r_addr, n_addr;
    logic          r_issue, n_issue;
    logic          r_rsp_vld, n_rsp_vld;
    t_addr         r_rsp_addr, n_rsp_addr;
    t_byte         r_sum, n_sum;
    t_byte         r_chk, n_chk;
    t_byte         r_cap [1:5];
    t_byte         n_cap [1:5];
    logic          r_res_done, n_res_done;
    logic          r_res_ok, n_res_ok;
    logic [1:0]    r_res_kind, n_res_kind;

    logic          is_sync1, is_sync2, is_plain, do_store;
    logic [IW-1:0] idx_inc;
    t_byte         len_new, lim_new, rsp_ext;
    logic          done_now, fin_ok;

    // Decode the offered byte
    assign is_sync1 = (i_byte == SYNC_FIRST);
    assign is_sync2 = (i_byte == SYNC_SECOND);
    assign is_plain = !is_sync1 && !is_sync2;
    assign do_store = is_sync1 || (is_sync2 && !r_hdr) || is_plain;
    assign idx_inc  = r_idx + IW'(1);
    assign len_new  = (do_store && r_idx == '0) ? i_byte : r_len;
    assign done_now = is_plain && (idx_inc == len_new);
    assign lim_new  = len_new - 8'd2;
    assign rsp_ext  = IW'(r_rsp_addr);
    assign fin_ok   = r_len_ok && (r_sum == r_chk);

    assign o_byte_rdy = (r_state == S_IDLE);
    assign o_res_vld  = (r_state == S_OUT);
    assign o_res      = '{frame_done: r_res_done, checksum_ok: r_res_ok,
                          command_kind: r_res_kind, steer_position: r_steer,
                          sail_position: r_sail, init_seen: r_init};

    // Next state
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_hdr      = r_hdr;
        n_len      = r_len;
        n_steer    = r_steer;
        n_sail     = r_sail;
        n_init     = r_init;
        n_len_ok   = r_len_ok;
        n_lim      = r_lim;
        n_end      = r_end;
        n_addr     = r_addr;
        n_issue    = r_issue;
        n_rsp_vld  = 1'b0;
        n_rsp_addr = r_addr;
        n_sum      = r_sum;
        n_chk      = r_chk;
        n_cap      = r_cap;
        n_res_done = r_res_done;
        n_res_ok   = r_res_ok;
        n_res_kind = r_res_kind;
        o_mem_req  = '0;
        case (r_state)
            S_IDLE: begin
                if (i_byte_vld) begin
                    // Store the byte and advance or resync the index
                    o_mem_req.wr_en   = do_store;
                    o_mem_req.wr_addr = r_idx[AW-1:0];
                    o_mem_req.wr_data = i_byte;
                    n_hdr = is_sync1;
                    n_len = len_new;
                    if (done_now) begin
                        n_idx = '0;
                    end else if (do_store) begin
                        n_idx = (idx_inc >= IW'(BUFFER_BYTES)) ? IW'(BUFFER_BYTES - 1)
                                                               : idx_inc;
                    end else begin
                        n_idx = '0;
                    end
                    n_res_done = 1'b0;
                    n_res_ok   = 1'b0;
                    n_res_kind = KIND_NONE;
                    if (done_now) begin
                        n_len_ok = (len_new >= 8'd3) && (len_new <= IW'(BUFFER_BYTES));
                        n_lim    = lim_new;
                        n_end    = (lim_new >= 8'd5) ? lim_new[AW-1:0] : AW'(5);
                        n_addr   = '0;
                        n_issue  = 1'b1;
                        n_sum    = '0;
                        n_state  = ((len_new >= 8'd3) && (len_new <= IW'(BUFFER_BYTES)))
                                   ? S_WALK : S_FIN;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_WALK: begin
                // Issue one read a cycle up to the last needed byte
                if (r_issue) begin
                    o_mem_req.rd_en   = 1'b1;
                    o_mem_req.rd_addr = r_addr;
                    n_rsp_vld         = 1'b1;
                    if (r_addr == r_end) begin
                        n_issue = 1'b0;
                    end else begin
                        n_addr = r_addr + AW'(1);
                    end
                end
                // Accumulate the sum, pick the check byte and the command bytes
                if (r_rsp_vld) begin
                    if (rsp_ext < r_lim) begin
                        n_sum = r_sum + i_rd_data;
                    end
                    if (rsp_ext == r_lim) begin
                        n_chk = i_rd_data;
                    end
                    if (r_rsp_addr >= AW'(1) && r_rsp_addr <= AW'(5)) begin
                        n_cap[r_rsp_addr[2:0]] = i_rd_data;
                    end
                    if (r_rsp_addr == r_end) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                // Judge the frame and latch the positions on a known command
                n_res_done = 1'b1;
                n_res_ok   = fin_ok;
                n_res_kind = KIND_NONE;
                if (fin_ok && (r_cap[1] == CMD_POSITION || r_cap[1] == CMD_INIT)) begin
                    n_steer    = {r_cap[2], r_cap[3]};
                    n_sail     = {r_cap[4], r_cap[5]};
                    n_res_kind = KIND_POS;
                    if (r_cap[1] == CMD_INIT) begin
                        n_init     = 1'b1;
                        n_res_kind = KIND_INIT;
                    end
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                // Hold the result until the output slot takes it
                if (i_res_rdy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_hdr     <= 1'b0;
            r_len     <= '0;
            r_steer   <= STEER_RESET;
            r_sail    <= '0;
            r_init    <= 1'b0;
            r_issue   <= 1'b0;
            r_rsp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_hdr     <= n_hdr;
            r_len     <= n_len;
            r_steer   <= n_steer;
            r_sail    <= n_sail;
            r_init    <= n_init;
            r_issue   <= n_issue;
            r_rsp_vld <= n_rsp_vld;
        end
    end

    // Walk and result payload
    always_ff @(posedge i_clk) begin
        r_len_ok   <= n_len_ok;
        r_lim      <= n_lim;
        r_end      <= n_end;
        r_addr     <= n_addr;
        r_rsp_addr <= n_rsp_addr;
        r_sum      <= n_sum;
        r_chk      <= n_chk;
        r_cap      <= n_cap;
        r_res_done <= n_res_done;
        r_res_ok   <= n_res_ok;
        r_res_kind <= n_res_kind;
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= IW'(BUFFER_BYTES - 1))
        else $error("write index beyond buffer end");

    a_init_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !$fell(r_init))
        else $error("init flag cleared without reset");

    a_fail_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && !fin_ok) |=> ($stable(r_steer) && $stable(r_sail)))
        else $error("positions changed on a failed frame");

    a_read_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_req.rd_en |-> (r_state == S_WALK))
        else $error("store read outside the checksum walk");

    a_write_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_req.wr_en |-> (r_state == S_IDLE && i_byte_vld))
        else $error("store write without an accepted item");

endmodule

/* rtl/core/sync_header_frame_receiver.sv */
// Top level: byte stream in, one result item per byte out through an output register.
// A byte that completes no frame goes straight to its result; one that completes a frame
// whose length L lies outside 3..BUFFER_BYTES is judged failed without reading the store;
// else the checksum walk first reads store bytes 0..max(L-2,5), one a cycle.
// One item at a time: no new byte is accepted until the last result enters the output register.
// Reset (i_rst_n low, synchronous) clears index, header, positions (steer 1400), valid bits.
module sync_header_frame_receiver (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [7:0]                        i_s_axis_tdata,  // [7:0] rx_byte
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [0] frame_done, [1] checksum_ok, [3:2] command_kind, [19:4] steer_position,
    // [35:20] sail_position, [36] init_seen, [39:37] zero
    output logic [shfr_pkg::RES_BYTES*8-1:0] o_m_axis_tdata
);
    import shfr_pkg::*;

    t_mem_req mem_req;
    t_byte    rd_data;
    logic     res_vld;
    logic     res_rdy;
    t_result  res;

    logic                   r_m_vld;
    logic [RES_BYTES*8-1:0] r_m_data;

    shfr_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    shfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte_vld (i_s_axis_tvalid),
        .i_byte     (i_s_axis_tdata),
        .o_byte_rdy (o_s_axis_tready),
        .o_mem_req  (mem_req),
        .i_rd_data  (rd_data),
        .o_res_vld  (res_vld),
        .o_res      (res),
        .i_res_rdy  (res_rdy)
    );

    // Output slot is free when empty or being drained
    assign res_rdy = !r_m_vld || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (res_rdy) begin
            r_m_vld <= res_vld;
        end
    end

    // Pack the result item, first field lowest
    always_ff @(posedge i_clk) begin
        if (res_vld && res_rdy) begin
            r_m_data <= {(RES_BYTES*8 - RES_BITS)'(0), res.init_seen, res.sail_position,
                         res.steer_position, res.command_kind, res.checksum_ok,
                         res.frame_done};
        end
    end

    assign o_m_axis_tvalid = r_m_vld;
    assign o_m_axis_tdata  = r_m_data;

endmodule

/* test/shfr_frame_checker.sv */
// Checker for the sync header frame receiver: predicts each result item and compares it.
module shfr_frame_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    input  logic                             i_s_axis_tready,
    input  logic [7:0]                       i_s_axis_tdata,   // [7:0] rx_byte
    input  logic                             i_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [0] frame_done, [1] checksum_ok, [3:2] command_kind, [19:4] steer_position,
    // [35:20] sail_position, [36] init_seen, [39:37] zero
    input  logic [shfr_pkg::RES_BYTES*8-1:0] i_m_axis_tdata,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_bytes_seen,
    output int                               o_frames_done,
    output int                               o_frames_ok,
    output int                               o_commands
);
    timeunit 1ns;
    timeprecision 1ps;
    import shfr_pkg::*;

    // Shadow copy of the receiver state
    t_byte       byte_store [BUFFER_BYTES];
    logic [8:0]  cursor;
    logic        sync_pending;
    logic [15:0] steer_latch;
    logic [15:0] sail_latch;
    logic        init_latch;

    t_result     expected_results [$];
    int          results_seen;

    task automatic report_failure(input string msg);
        $display("[%0t] result %0d: %s", $time, results_seen, msg);
        o_fail_count++;
    endtask

    // Write a byte at the cursor and advance it
    task automatic store_at_cursor(input t_byte b);
        if (cursor < BUFFER_BYTES) begin
            byte_store[cursor] = b;
        end
        cursor = cursor + 9'd1;
    endtask

    // Advance the shadow state by one received byte and work out its result item
    task automatic receive_byte(input t_byte b, output t_result res);
        int         len;
        logic [7:0] sum;
        res                = '0;
        res.command_kind   = KIND_NONE;
        if (b == SYNC_FIRST) begin
            sync_pending = 1'b1;
            store_at_cursor(b);
        end else if (b == SYNC_SECOND) begin
            if (sync_pending) begin
                cursor = '0;
            end else begin
                store_at_cursor(b);
            end
            sync_pending = 1'b0;
        end else begin
            store_at_cursor(b);
            sync_pending = 1'b0;
            if (cursor == {1'b0, byte_store[0]}) begin
                cursor         = '0;
                res.frame_done = 1'b1;
            end
        end
        if (cursor >= BUFFER_BYTES) begin
            cursor = 9'(BUFFER_BYTES - 1);
        end

        // Length-completed frame: additive checksum, then command latch
        if (res.frame_done) begin
            len = int'(byte_store[0]);
            if (len >= 3 && len <= BUFFER_BYTES) begin
                sum = '0;
                for (int i = 0; i < len - 2; i++) begin
                    sum += byte_store[i];
                end
                res.checksum_ok = (sum == byte_store[len-2]);
            end
            if (res.checksum_ok &&
                (byte_store[1] == CMD_POSITION || byte_store[1] == CMD_INIT)) begin
                steer_latch      = {byte_store[2], byte_store[3]};
                sail_latch       = {byte_store[4], byte_store[5]};
                res.command_kind = KIND_POS;
                if (byte_store[1] == CMD_INIT) begin
                    init_latch       = 1'b1;
                    res.command_kind = KIND_INIT;
                end
            end
        end
        res.steer_position = steer_latch;
        res.sail_position  = sail_latch;
        res.init_seen      = init_latch;
    endtask

    // Compare one result item with the oldest expectation, field by field
    task automatic compare_result(input t_result want, input logic [RES_BYTES*8-1:0] raw);
        t_result got;
        got.frame_done     = raw[0];
        got.checksum_ok    = raw[1];
        got.command_kind   = raw[3:2];
        got.steer_position = raw[19:4];
        got.sail_position  = raw[35:20];
        got.init_seen      = raw[36];
        if (got.frame_done !== want.frame_done)
            report_failure($sformatf("frame_done expected %0b, got %0b",
                                     want.frame_done, got.frame_done));
        if (got.checksum_ok !== want.checksum_ok)
            report_failure($sformatf("checksum_ok expected %0b, got %0b",
                                     want.checksum_ok, got.checksum_ok));
        if (got.command_kind !== want.command_kind)
            report_failure($sformatf("command_kind expected %0d, got %0d",
                                     want.command_kind, got.command_kind));
        if (got.steer_position !== want.steer_position)
            report_failure($sformatf("steer_position expected 0x%04h, got 0x%04h",
                                     want.steer_position, got.steer_position));
        if (got.sail_position !== want.sail_position)
            report_failure($sformatf("sail_position expected 0x%04h, got 0x%04h",
                                     want.sail_position, got.sail_position));
        if (got.init_seen !== want.init_seen)
            report_failure($sformatf("init_seen expected %0b, got %0b",
                                     want.init_seen, got.init_seen));
    endtask

    // Watch both channels at each rising edge
    always @(posedge i_clk) begin
        t_result res;
        if (!i_rst_n) begin
            foreach (byte_store[i]) byte_store[i] = '0;
            cursor        = '0;
            sync_pending  = 1'b0;
            steer_latch   = STEER_RESET;
            sail_latch    = '0;
            init_latch    = 1'b0;
            expected_results.delete();
            results_seen  = 0;
            o_fail_count  = 0;
            o_bytes_seen  = 0;
            o_frames_done = 0;
            o_frames_ok   = 0;
            o_commands    = 0;
        end else begin
            // Predict on every accepted input item
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                receive_byte(i_s_axis_tdata, res);
                expected_results.push_back(res);
                o_bytes_seen++;
                if (res.frame_done) o_frames_done++;
                if (res.checksum_ok) o_frames_ok++;
                if (res.command_kind != KIND_NONE) o_commands++;
            end
            // Check every accepted result item
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    report_failure($sformatf("unexpected result item 0x%010h",
                                             i_m_axis_tdata));
                end else begin
                    compare_result(expected_results.pop_front(), i_m_axis_tdata);
                end
                results_seen++;
            end
        end
        o_pending = expected_results.size();
    end

endmodule

/* test/sync_header_frame_receiver_tb.sv */
// Testbench top: drives bytes into the frame receiver, stalls its output and gives the verdict.
module sync_header_frame_receiver_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import shfr_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 110;
    localparam int TAIL_CYCLES  = 40;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [RES_BYTES*8-1:0] m_axis_tdata;

    int fail_count;
    int pending;
    int bytes_seen;
    int frames_done;
    int frames_ok;
    int commands;
    int cycle_count = 0;
    int items_sent  = 0;
    bit calm        = 1'b0;

    always #2 clk = ~clk;

    sync_header_frame_receiver u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .o_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .o_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .o_m_axis_tdata  (m_axis_tdata)
    );

    shfr_frame_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_bytes_seen    (bytes_seen),
        .o_frames_done   (frames_done),
        .o_frames_ok     (frames_ok),
        .o_commands      (commands)
    );

    // Gap length: mostly short, a few long, none during calm stretches
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 80) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Random byte, biased towards the sync codes and the extremes
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) return SYNC_FIRST;
        if (r < 20) return SYNC_SECOND;
        if (r < 25) return 8'h00;
        if (r < 30) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // Offer one item after a random gap and hold it until accepted
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        items_sent++;
    endtask

    // Build a frame of the given length and send its first keep bytes
    task automatic send_frame(input int len, input logic [7:0] cmd, input bit good_sum,
                              input int keep);
        logic [7:0] body [256];
        logic [7:0] cks;
        logic [7:0] flip;
        body[0] = len[7:0];
        for (int i = 1; i < len; i++) begin
            body[i] = (i == 1) ? cmd : pick_byte();
            // keep a sync pair out of the frame body
            if (body[i-1] == SYNC_FIRST && body[i] == SYNC_SECOND) body[i] = 8'h5B;
        end
        if (len >= 3) begin
            cks = '0;
            for (int i = 0; i < len - 2; i++) cks += body[i];
            if (body[len-3] == SYNC_FIRST && cks == SYNC_SECOND) begin
                body[len-3] = body[len-3] ^ 8'h01;
                cks         = cks - 8'h01;
            end
            flip = 8'h01 << $urandom_range(0, 7);
            if (good_sum)
                body[len-2] = cks;
            else if (body[len-3] == SYNC_FIRST && (cks ^ flip) == SYNC_SECOND)
                body[len-2] = cks ^ 8'hFF;
            else
                body[len-2] = cks ^ flip;
        end
        // the closing byte must be a plain one
        if (len >= 2 && (body[len-1] == SYNC_FIRST || body[len-1] == SYNC_SECOND))
            body[len-1] = 8'h00;
        for (int i = 0; i < keep && i < len; i++) send_byte(body[i]);
    endtask

    task automatic send_sync();
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
    endtask

    // Toggle between stretches with and without idling
    initial begin
        forever begin
            calm <= ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(100, 600)) @(posedge clk);
        end
    end

    // Output side: accept in bursts with random stalls
    initial begin
        int gap;
        wait (rst_n);
        @(posedge clk);
        forever begin
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
            gap = pick_gap();
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    // Give up on a hang
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("sync_header_frame_receiver_tb failed");
            $finish;
        end
    end

    // Stimulus and verdict
    initial begin
        int         r;
        int         len;
        int         random_start;
        bit         aligned;
        logic [7:0] cmd;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Zero length byte, stray 5A, lone A5: nothing completes
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(SYNC_SECOND);
        send_byte(SYNC_FIRST);
        send_byte(8'h33);
        send_sync();
        // Lengths one and two complete and fail the check
        send_byte(8'h01);
        send_byte(8'h02);
        send_byte(8'h7F);
        // Short position frame: sail comes from stale bytes
        send_byte(8'h04);
        send_byte(CMD_POSITION);
        send_byte(8'hAA);
        send_byte(8'h80);
        // Init frame with all-ones positions
        send_byte(8'h08);
        send_byte(CMD_INIT);
        repeat (4) send_byte(8'hFF);
        send_byte(8'hAD);
        send_byte(8'h00);
        // Unknown command passes without latching
        send_byte(8'h03);
        send_byte(8'h03);
        send_byte(8'h11);

        // Largest frame, then a run that fills the buffer
        send_sync();
        send_frame(BUFFER_BYTES, CMD_POSITION, 1'b1, BUFFER_BYTES);
        send_sync();
        send_frame(255, pick_byte(), 1'b1, BUFFER_BYTES + 10);

        // Random part: mostly synced frames, some noise and broken frames
        aligned      = 1'b0;
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                if (!aligned || $urandom_range(0, 1)) send_sync();
                r   = $urandom_range(0, 99);
                len = (r < 10) ? $urandom_range(1, 2) :
                      (r < 85) ? $urandom_range(3, 12) : $urandom_range(13, 48);
                r   = $urandom_range(0, 99);
                cmd = (r < 40) ? CMD_POSITION : (r < 70) ? CMD_INIT : pick_byte();
                send_frame(len, cmd, $urandom_range(0, 4) != 0, len);
                aligned = 1'b1;
            end else if (r < 85) begin
                repeat ($urandom_range(1, 8)) send_byte(pick_byte());
                aligned = 1'b0;
            end else if (r < 95) begin
                send_sync();
                len = $urandom_range(4, 20);
                send_frame(len, CMD_POSITION, 1'b1, $urandom_range(1, len - 1));
                aligned = 1'b0;
            end else begin
                // length byte beyond the buffer, cut short
                send_sync();
                send_frame($urandom_range(BUFFER_BYTES + 1, 255), pick_byte(), 1'b1,
                           $urandom_range(3, 10));
                aligned = 1'b0;
            end
        end

        // Drain and settle
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d bytes: %0d frames completed, %0d passed the checksum, %0d commands",
                 bytes_seen, frames_done, frames_ok, commands);
        $display("sync codes, short and full-size frames, buffer overflow, stalls on both sides");
        if (fail_count == 0 && pending == 0) begin
            $display("sync_header_frame_receiver_tb passed");
        end else begin
            $display("sync_header_frame_receiver_tb failed");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/shfr_pkg.sv
rtl/core/shfr_store.sv
rtl/core/shfr_ctrl.sv
rtl/core/sync_header_frame_receiver.sv
test/shfr_frame_checker.sv
test/sync_header_frame_receiver_tb.sv
